@@ rtl/sector_buffer_cache_tags_assert.svh @@
// assertion macros for the sector buffer cache tag engine
`ifndef SECTOR_BUFFER_CACHE_TAGS_ASSERT_SVH
`define SECTOR_BUFFER_CACHE_TAGS_ASSERT_SVH
`ifndef ASSERT_OFF
`define SBCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SBCT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`else
`define SBCT_ASSERT(lbl, prop, msg)
`define SBCT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/sbct_pkg.sv @@
`default_nettype none
package sbct_pkg;

   localparam int ENTRIES     = 16;
   localparam int SECTOR_BITS = 32;
   localparam int IDX_BITS    = $clog2(ENTRIES);

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   localparam logic [1:0] ACT_NONE       = 2'd0;
   localparam logic [1:0] ACT_FILL       = 2'd1;
   localparam logic [1:0] ACT_WRITE_BACK = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] sector;
      logic        fill_ok;
      logic [15:0] write_fail_mask;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  entry_index;
      logic [31:0] out_sector;
      logic        hit;
      logic        status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic                   valid;
      logic                   dirty;
      logic [SECTOR_BITS-1:0] sector;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic wr;
   } cell_ctl_type;

endpackage
`default_nettype wire

@@ rtl/sbct_cell.sv @@
`default_nettype none
module sbct_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sbct_pkg::cell_ctl_type ctl,
   input  wire sbct_pkg::entry_type  nbr_in,
   input  wire sbct_pkg::entry_type  wr_data,
   output sbct_pkg::entry_type       q
);
   import sbct_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr) begin
         entry_in = wr_data;
      end else if (ctl.shift) begin
         entry_in = nbr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q = entry_ff;

endmodule
`default_nettype wire

@@ rtl/sector_buffer_cache_tags.sv @@
// channel   ports                          direction
// request   req_valid req_stall req_payload in
// response  rsp_valid rsp_stall rsp_payload out
//
// read and write: after acceptance, a ring scan, then a commit
// flush: one full ring rotation, then a closing response unless a write-back failed
// the ring turns one cell per unstalled cycle and is home before the next request
// response stalls pause the ring wherever a response must be issued
// synchronous reset clears all entries and the victim pointer, no clearing pass
`default_nettype none
`include "sector_buffer_cache_tags_assert.svh"
module sector_buffer_cache_tags (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sbct_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sbct_pkg::rsp_type      rsp_payload
);
   import sbct_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_COMMIT = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_FINAL  = 5'b10000
   } state_type;

   localparam logic [IDX_BITS-1:0] CNT_LAST = IDX_BITS'(ENTRIES - 1);

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]   victim_ff, victim_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_BITS-1:0]   inv_idx_ff, inv_idx_in;
   logic                  hit_found_ff, hit_found_in;
   logic                  inv_found_ff, inv_found_in;
   logic                  stop_ff, stop_in;
   req_type               req_ff, req_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   entry_type             cell_q [ENTRIES];
   cell_ctl_type          cell_ctl [ENTRIES];
   entry_type             head;
   entry_type             tail;
   entry_type             wr_data;
   logic                  shift;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_idx;

   logic                  out_free;
   logic                  emit;
   rsp_type               rsp_new;
   logic [SECTOR_BITS-1:0] sec_m;
   logic                  wb;
   logic                  fail;
   logic [IDX_BITS-1:0]   sel_idx;

   assign head      = cell_q[0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign sec_m     = SECTOR_BITS'(req_ff.sector);

   // entry ring
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type nbr;
      if (i == ENTRIES - 1) begin : g_tail
         assign nbr = tail;
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      assign cell_ctl[i].shift = shift;
      assign cell_ctl[i].wr    = wr_en && (wr_idx == IDX_BITS'(i));
      sbct_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl[i]),
         .nbr_in  (nbr),
         .wr_data (wr_data),
         .q       (cell_q[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      victim_in    = victim_ff;
      hit_idx_in   = hit_idx_ff;
      inv_idx_in   = inv_idx_ff;
      hit_found_in = hit_found_ff;
      inv_found_in = inv_found_ff;
      stop_in      = stop_ff;
      req_in       = req_ff;
      shift        = 1'b0;
      tail         = head;
      wr_en        = 1'b0;
      wr_idx       = '0;
      wr_data      = '0;
      emit         = 1'b0;
      rsp_new      = '0;
      wb           = 1'b0;
      fail         = 1'b0;
      sel_idx      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_payload;
               cnt_in       = '0;
               hit_found_in = 1'b0;
               inv_found_in = 1'b0;
               stop_in      = 1'b0;
               case (req_payload.command)
                  CMD_READ, CMD_WRITE: state_in = ST_SCAN;
                  CMD_FLUSH:           state_in = ST_FLUSH;
                  default:             state_in = ST_FINAL;
               endcase
            end
         end
         ST_SCAN: begin
            shift = 1'b1;
            if (head.valid && head.sector == sec_m && !hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = cnt_ff;
            end
            if (!head.valid && !inv_found_ff) begin
               inv_found_in = 1'b1;
               inv_idx_in   = cnt_ff;
            end
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = ST_COMMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               if (hit_found_ff) begin
                  sel_idx = hit_idx_ff;
               end else if (inv_found_ff) begin
                  sel_idx = inv_idx_ff;
               end else begin
                  sel_idx   = victim_ff;
                  victim_in = (victim_ff == CNT_LAST) ? '0 : victim_ff + 1'b1;
               end
               wr_idx          = sel_idx;
               wr_data.valid   = 1'b1;
               wr_data.sector  = sec_m;
               emit            = 1'b1;
               rsp_new.entry_index = 4'(sel_idx);
               rsp_new.out_sector  = 32'(sec_m);
               rsp_new.hit         = hit_found_ff;
               rsp_new.last        = 1'b1;
               if (req_ff.command == CMD_WRITE) begin
                  wr_en         = 1'b1;
                  wr_data.dirty = 1'b1;
                  rsp_new.action = ACT_NONE;
               end else if (hit_found_ff) begin
                  rsp_new.action = ACT_NONE;
               end else begin
                  wr_en          = req_ff.fill_ok;
                  wr_data.dirty  = 1'b0;
                  rsp_new.action = ACT_FILL;
                  rsp_new.status = !req_ff.fill_ok;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            wb   = head.valid && head.dirty && !stop_ff;
            fail = (int'(cnt_ff) < 16) && req_ff.write_fail_mask[4'(cnt_ff)];
            if (!wb || out_free) begin
               shift = 1'b1;
               if (wb) begin
                  emit                = 1'b1;
                  rsp_new.action      = ACT_WRITE_BACK;
                  rsp_new.entry_index = 4'(cnt_ff);
                  rsp_new.out_sector  = 32'(head.sector);
                  rsp_new.status      = fail;
                  rsp_new.last        = fail;
                  tail.dirty          = fail;
                  stop_in             = fail;
               end
               if (cnt_ff == CNT_LAST) begin
                  cnt_in   = '0;
                  state_in = (stop_ff || (wb && fail)) ? ST_IDLE : ST_FINAL;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               emit         = 1'b1;
               rsp_new.last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in       = rsp_new;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         victim_ff    <= '0;
         hit_found_ff <= 1'b0;
         inv_found_ff <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         victim_ff    <= victim_in;
         hit_found_ff <= hit_found_in;
         inv_found_ff <= inv_found_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      hit_idx_ff <= hit_idx_in;
      inv_idx_ff <= inv_idx_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SBCT_ASSERT(a_accept_leaves_idle, (req_valid && !req_stall) |=> (state_ff != ST_IDLE), "accepted request left controller idle")
   `SBCT_ASSERT(a_victim_only_in_commit, (state_ff != ST_COMMIT) |=> $stable(victim_ff), "victim pointer moved outside commit")
   `SBCT_ASSERT(a_scan_ends_in_commit, (state_ff == ST_SCAN && cnt_ff == CNT_LAST) |=> (state_ff == ST_COMMIT), "scan did not end in commit")
   `SBCT_ASSERT_IMPL(a_idle_ring_home, state_ff == ST_IDLE, cnt_ff == '0, "ring not home while idle")

endmodule
`default_nettype wire
